>>> hdl/dfas_pkg.sv
// ----------------------------------------------------------------------------
// dfas_pkg
// Shared constants, codes and types of the decimal floating-point add/sub unit.
// ----------------------------------------------------------------------------
package dfas_pkg;

  localparam int DEF_WORK_DIGITS    = 15;
  localparam int DEF_OPERAND_DIGITS = 7;

  localparam int OUT_DIGITS    = 14;
  localparam int EXP_W         = 10;
  localparam int RES_EXP_W     = 9;
  localparam int OUT_FIELDS_W  = 1 + 4 * OUT_DIGITS + RES_EXP_W;
  localparam int OUT_TDATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PRECISION = 2'd0,
    CFG_EXP_MIN   = 2'd1,
    CFG_EXP_MAX   = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    STATUS_OK      = 3'd0,
    STATUS_RES_OVF = 3'd1,
    STATUS_RES_UNF = 3'd2,
    STATUS_OP1_OVF = 3'd3,
    STATUS_OP1_UNF = 3'd4,
    STATUS_OP2_OVF = 3'd5,
    STATUS_OP2_UNF = 3'd6
  } status_e;

  typedef struct packed {
    logic [3:0] precision;
    logic [7:0] exp_min;
    logic [6:0] exp_max;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{precision: 4'd7, exp_min: 8'h9D, exp_max: 7'd99};

  typedef struct packed {
    status_e                status;
    logic                   sign;
    logic [4*OUT_DIGITS-1:0] digits;
    logic [RES_EXP_W-1:0]   exponent;
  } res_t;

endpackage

>>> hdl/decimal_float_add_sub_unit.sv
// ----------------------------------------------------------------------------
// decimal_float_add_sub_unit
// Decimal floating-point add/subtract with range checks and half-to-even
// rounding to a configurable number of digits.
// ----------------------------------------------------------------------------
// The unit takes one item per clock while the sink takes results, and returns
// one result item for each. An accepted item is held in the input register;
// the whole operation (range check, alignment, BCD add/subtract,
// normalisation, rounding) is one pass of logic into the result register,
// which loads it when the output is empty or its result is being taken.
// s_axis_tready depends combinationally on m_axis_tready: while the sink takes
// results the unit never refuses an item. The configuration port may only be
// written while no item is in flight.
module decimal_float_add_sub_unit import dfas_pkg::*; #(
  parameter int WORK_DIGITS    = DEF_WORK_DIGITS,
  parameter int OPERAND_DIGITS = DEF_OPERAND_DIGITS,
  localparam int OW            = 4 * OPERAND_DIGITS,
  localparam int IN_FIELDS_W   = 2 * (1 + OW + 8),
  localparam int IN_TDATA_W    = ((IN_FIELDS_W + 7) / 8) * 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // first_sign, first_digits, first_exponent, second_sign, second_digits,
  // second_exponent
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // opcode
  input  logic                   s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // result_sign, result_digits, result_exponent
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // status
  output logic [2:0]             m_axis_tuser
);

  localparam int F1_DIG  = 1;
  localparam int F1_EXP  = 1 + OW;
  localparam int F2_SIGN = 9 + OW;
  localparam int F2_DIG  = 10 + OW;
  localparam int F2_EXP  = 10 + 2 * OW;

  cfg_t                   cfg_q, cfg_d;
  logic                   in_valid_q, in_valid_d;
  logic                   out_valid_q, out_valid_d;
  logic [IN_FIELDS_W-1:0] data_q;
  logic                   op_q;
  res_t                   res_q, res_d;
  logic                   in_take, advance;

  // configuration registers
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_PRECISION: cfg_d.precision = cfg_data_i[3:0];
        CFG_EXP_MIN:   cfg_d.exp_min   = cfg_data_i;
        CFG_EXP_MAX:   cfg_d.exp_max   = cfg_data_i[6:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  // handshake
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= CFG_RESET;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      data_q <= s_axis_tdata[IN_FIELDS_W-1:0];
      op_q   <= s_axis_tuser;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  dfas_arith #(
    .WORK_DIGITS    (WORK_DIGITS),
    .OPERAND_DIGITS (OPERAND_DIGITS)
  ) u_arith (
    .op_sub_i (op_q),
    .s1_i     (data_q[0]),
    .d1_i     (data_q[F1_DIG +: OW]),
    .e1_i     ($signed(data_q[F1_EXP +: 8])),
    .s2_i     (data_q[F2_SIGN]),
    .d2_i     (data_q[F2_DIG +: OW]),
    .e2_i     ($signed(data_q[F2_EXP +: 8])),
    .cfg_i    (cfg_q),
    .res_o    (res_d)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TDATA_W'({res_q.exponent, res_q.digits, res_q.sign});
  assign m_axis_tuser  = res_q.status;

endmodule

>>> hdl/dfas_bcd_adder.sv
// ----------------------------------------------------------------------------
// dfas_bcd_adder
// Packed BCD adder: one binary add with a bias of six per digit, then a
// per-digit correction where no decimal carry left the digit.
// ----------------------------------------------------------------------------
module dfas_bcd_adder #(
  parameter int DIGITS = 15
) (
  input  logic [4*DIGITS-1:0] x_i,
  input  logic [4*DIGITS-1:0] y_i,
  input  logic                cin_i,
  output logic [4*DIGITS-1:0] sum_o,
  output logic                cout_o
);

  logic [4*DIGITS:0] x_ext;
  logic [4*DIGITS:0] y_ext;
  logic [4*DIGITS:0] raw;
  logic              dig_carry;

  always_comb begin
    x_ext = {1'b0, x_i};
    y_ext = '0;
    for (int k = 0; k < DIGITS; k++) begin
      y_ext[4*k +: 4] = y_i[4*k +: 4] + 4'd6;
    end
    raw = x_ext + y_ext + {{(4*DIGITS){1'b0}}, cin_i};
    for (int k = 0; k < DIGITS; k++) begin
      dig_carry = raw[4*k+4] ^ x_ext[4*k+4] ^ y_ext[4*k+4];
      sum_o[4*k +: 4] = dig_carry ? raw[4*k +: 4] : raw[4*k +: 4] - 4'd6;
    end
    cout_o = raw[4*DIGITS];
  end

endmodule

>>> hdl/dfas_arith.sv
// ----------------------------------------------------------------------------
// dfas_arith
// Operand range check, alignment, magnitude add/subtract, normalisation,
// half-to-even rounding and result range check for one item.
// ----------------------------------------------------------------------------
module dfas_arith import dfas_pkg::*; #(
  parameter int WORK_DIGITS    = DEF_WORK_DIGITS,
  parameter int OPERAND_DIGITS = DEF_OPERAND_DIGITS
) (
  input  logic                        op_sub_i,
  input  logic                        s1_i,
  input  logic [4*OPERAND_DIGITS-1:0] d1_i,
  input  logic signed [7:0]           e1_i,
  input  logic                        s2_i,
  input  logic [4*OPERAND_DIGITS-1:0] d2_i,
  input  logic signed [7:0]           e2_i,
  input  cfg_t                        cfg_i,
  output res_t                        res_o
);

  localparam int WB  = 4 * WORK_DIGITS;
  localparam int OW  = 4 * OPERAND_DIGITS;
  localparam int MD  = WORK_DIGITS + 1;
  localparam int ND  = (MD > OUT_DIGITS + 1) ? MD : OUT_DIGITS + 1;
  localparam int LZW = $clog2(MD + 1);
  localparam int OB  = 4 * OUT_DIGITS;
  localparam int XW  = 4 * (WORK_DIGITS + OPERAND_DIGITS);
  localparam int MXW = 4 * (MD + OUT_DIGITS + 1);

  logic [OW-1:0]           c1, c2;
  logic [XW-1:0]           x1, x2;
  logic [WB-1:0]           w1, w2, a, b, na, nb;
  logic [WB-1:0]           sum_ab, dif_ab, dif_ba;
  logic                    co_sum, co_ab, co_ba;
  logic                    e_ge;
  logic [8:0]              e_diff;
  logic [7:0]              sh1, sh2;
  logic signed [7:0]       e_big;
  logic                    s2_eff, sub_eff, sign;
  logic [4*MD-1:0]         mag;
  logic                    mag_zero;
  logic [LZW-1:0]          lz;
  logic [MXW-1:0]          mext;
  logic [4*ND-1:0]         norm_pre, norm;
  logic [3:0]              p;
  logic [3:0]              rd;
  logic                    sticky, q_lsb, rnd_up;
  logic [OB-1:0]           kept, inc, rsum;
  logic                    rco;
  logic signed [EXP_W-1:0] e1_x, e2_x, emin_x, emax_x, e_norm, e_fin;

  // alignment
  always_comb begin
    for (int i = 0; i < OPERAND_DIGITS; i++) begin
      c1[4*i +: 4] = (d1_i[4*i +: 4] > 4'd9) ? 4'd9 : d1_i[4*i +: 4];
      c2[4*i +: 4] = (d2_i[4*i +: 4] > 4'd9) ? 4'd9 : d2_i[4*i +: 4];
    end
    x1 = {c1, {WB{1'b0}}};
    x2 = {c2, {WB{1'b0}}};
    w1 = x1[XW-1 -: WB];
    w2 = x2[XW-1 -: WB];
    e_ge   = (e1_i >= e2_i);
    e_diff = e_ge ? ({e1_i[7], e1_i} - {e2_i[7], e2_i})
                  : ({e2_i[7], e2_i} - {e1_i[7], e1_i});
    sh1   = e_ge ? 8'd0 : e_diff[7:0];
    sh2   = e_ge ? e_diff[7:0] : 8'd0;
    e_big = e_ge ? e1_i : e2_i;
    a = (sh1 >= 8'(WORK_DIGITS)) ? '0 : (w1 >> {sh1, 2'b00});
    b = (sh2 >= 8'(WORK_DIGITS)) ? '0 : (w2 >> {sh2, 2'b00});
    for (int i = 0; i < WORK_DIGITS; i++) begin
      na[4*i +: 4] = 4'd9 - a[4*i +: 4];
      nb[4*i +: 4] = 4'd9 - b[4*i +: 4];
    end
  end

  dfas_bcd_adder #(.DIGITS(WORK_DIGITS)) u_add_ab (
    .x_i(a), .y_i(b), .cin_i(1'b0), .sum_o(sum_ab), .cout_o(co_sum)
  );

  dfas_bcd_adder #(.DIGITS(WORK_DIGITS)) u_sub_ab (
    .x_i(a), .y_i(nb), .cin_i(1'b1), .sum_o(dif_ab), .cout_o(co_ab)
  );

  dfas_bcd_adder #(.DIGITS(WORK_DIGITS)) u_sub_ba (
    .x_i(b), .y_i(na), .cin_i(1'b1), .sum_o(dif_ba), .cout_o(co_ba)
  );

  // magnitude, normalisation and rounding decision
  always_comb begin
    s2_eff  = s2_i ^ op_sub_i;
    sub_eff = s1_i ^ s2_eff;
    if (!sub_eff) begin
      mag  = {3'b000, co_sum, sum_ab};
      sign = s1_i;
    end else if (co_ab) begin
      mag  = {4'h0, dif_ab};
      sign = s1_i;
    end else begin
      mag  = {4'h0, dif_ba};
      sign = s2_eff;
    end
    mag_zero = (mag == '0);

    lz = LZW'(MD);
    for (int j = 0; j < MD; j++) begin
      if (mag[4*j +: 4] != 4'h0) lz = LZW'(MD - 1 - j);
    end

    mext     = {mag, {(4*(OUT_DIGITS+1)){1'b0}}};
    norm_pre = mext[MXW-1 -: 4*ND];
    norm     = norm_pre << {lz, 2'b00};

    p = cfg_i.precision;
    if (p == 4'd0) p = 4'd1;
    if (p > 4'(OUT_DIGITS)) p = 4'(OUT_DIGITS);

    kept  = '0;
    inc   = '0;
    rd    = 4'h0;
    q_lsb = 1'b0;
    sticky = 1'b0;
    for (int j = 0; j < OUT_DIGITS; j++) begin
      if (j < int'(p)) kept[4*(OUT_DIGITS-1-j) +: 4] = norm[4*(ND-1-j) +: 4];
      if (j + 1 == int'(p)) q_lsb = norm[4*(ND-1-j)];
    end
    for (int j = 0; j < ND; j++) begin
      if (j == int'(p)) rd = norm[4*(ND-1-j) +: 4];
      if (j > int'(p) && norm[4*(ND-1-j) +: 4] != 4'h0) sticky = 1'b1;
    end
    rnd_up = (rd > 4'd5) || ((rd == 4'd5) && (sticky || q_lsb));
    for (int j = 0; j < OUT_DIGITS; j++) begin
      if (j + 1 == int'(p)) inc[4*(OUT_DIGITS-1-j)] = rnd_up;
    end
  end

  dfas_bcd_adder #(.DIGITS(OUT_DIGITS)) u_round (
    .x_i(kept), .y_i(inc), .cin_i(1'b0), .sum_o(rsum), .cout_o(rco)
  );

  // exponent and status
  always_comb begin
    e1_x   = EXP_W'(e1_i);
    e2_x   = EXP_W'(e2_i);
    emin_x = EXP_W'($signed(cfg_i.exp_min));
    emax_x = EXP_W'(cfg_i.exp_max);
    e_norm = EXP_W'(e_big) + EXP_W'(1) - EXP_W'(lz);
    e_fin  = e_norm + EXP_W'(rco);

    res_o = '{status: STATUS_OK, sign: 1'b0, digits: '0, exponent: '0};
    if (e1_x > emax_x) begin
      res_o.status = STATUS_OP1_OVF;
    end else if (e1_x < emin_x) begin
      res_o.status = STATUS_OP1_UNF;
    end else if (e2_x > emax_x) begin
      res_o.status = STATUS_OP2_OVF;
    end else if (e2_x < emin_x) begin
      res_o.status = STATUS_OP2_UNF;
    end else if (mag_zero) begin
      res_o.status = STATUS_OK;
    end else if (e_fin > emax_x) begin
      res_o.status = STATUS_RES_OVF;
    end else if (e_fin < emin_x) begin
      res_o.status = STATUS_RES_UNF;
    end else begin
      res_o.sign     = sign;
      res_o.digits   = rco ? {4'h1, {(OB-4){1'b0}}} : rsum;
      res_o.exponent = e_fin[RES_EXP_W-1:0];
    end
  end

endmodule

>>> hdl/dfas_checker.sv
// ----------------------------------------------------------------------------
// dfas_checker
// Port-level checks of the decimal floating-point add/sub unit.
// ----------------------------------------------------------------------------
module dfas_checker import dfas_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [2:0]             m_axis_tuser
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready
    |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // no bubble while the sink takes results
  a_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input refused while output drains");

  // error status carries an all-zero result
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != STATUS_OK) |-> (m_axis_tdata == '0))
    else $error("error item with nonzero result");

  // result normalised: zero leading digit only for a true zero
  a_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == STATUS_OK)
    && (m_axis_tdata[4*OUT_DIGITS -: 4] == 4'h0) |-> (m_axis_tdata == '0))
    else $error("result not normalised");

endmodule

bind decimal_float_add_sub_unit dfas_checker u_dfas_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

>>> tb/decimal_float_add_sub_unit_test.sv
// ----------------------------------------------------------------------------
// decimal_float_add_sub_unit_test
// Self-checking bench for the decimal floating-point add/subtract unit. A
// directed set of operations covering range faults, carries, borrows, ties
// and alignment loss is followed by random operations under seven register
// settings. Both stream sides idle in random bursts. Every result is checked
// against an in-bench model of the arithmetic and rounding.
// ----------------------------------------------------------------------------
module decimal_float_add_sub_unit_test;
  import dfas_pkg::*;

  localparam int WORK = DEF_WORK_DIGITS;
  localparam int OPD  = DEF_OPERAND_DIGITS;
  localparam int IN_W = ((2 * (1 + 4 * OPD + 8) + 7) / 8) * 8;
  localparam int RANDOM_PER_PHASE = 150;
  localparam int PHASES = 7;

  localparam logic OP_ADD = 1'b0;
  localparam logic OP_SUB = 1'b1;
  localparam logic PLUS   = 1'b0;
  localparam logic MINUS  = 1'b1;

  typedef struct packed {
    logic           opcode;
    logic           sign_a;
    logic [4*OPD-1:0] digits_a;
    logic [7:0]     exp_a;
    logic           sign_b;
    logic [4*OPD-1:0] digits_b;
    logic [7:0]     exp_b;
  } operation_t;

  class dfas_scoreboard;
    logic [3:0] precision;
    logic [7:0] exp_min;
    logic [6:0] exp_max;
    res_t expected_q[$];
    int unsigned mismatches;
    int unsigned results_seen;
    int unsigned status_seen[8];

    function new();
      precision = CFG_RESET.precision;
      exp_min   = CFG_RESET.exp_min;
      exp_max   = CFG_RESET.exp_max;
    endfunction

    function void set_config(logic [3:0] prec, logic [7:0] lo, logic [6:0] hi);
      precision = prec;
      exp_min   = lo;
      exp_max   = hi;
    endfunction

    function longint unsigned ten_pow(int k);
      longint unsigned v = 1;
      repeat (k) v = v * 10;
      return v;
    endfunction

    // significand as an integer of WORK digits, shifted right by sh digits
    function longint unsigned align(logic [4*OPD-1:0] bcd, int sh);
      longint unsigned v;
      logic [3:0] nib;
      v = 0;
      if (sh >= WORK) return 0;
      for (int i = 0; i < OPD; i++) begin
        if (i + sh >= WORK) break;
        nib = bcd[4*(OPD-1-i) +: 4];
        if (nib > 4'd9) nib = 4'd9;
        v += nib * ten_pow(WORK - 1 - i - sh);
      end
      return v;
    endfunction

    function res_t rounded_sum(operation_t it);
      res_t r;
      int ea, eb, lo, hi, e, p, n, sh_a, sh_b;
      logic sa, sb, sign;
      longint unsigned a, b, mag, q, dv, rem, half;
      r = '0;
      r.status = STATUS_OK;
      ea = int'(signed'(it.exp_a));
      eb = int'(signed'(it.exp_b));
      lo = int'(signed'(exp_min));
      hi = int'(exp_max);
      if (ea > hi) begin
        r.status = STATUS_OP1_OVF;
        return r;
      end
      if (ea < lo) begin
        r.status = STATUS_OP1_UNF;
        return r;
      end
      if (eb > hi) begin
        r.status = STATUS_OP2_OVF;
        return r;
      end
      if (eb < lo) begin
        r.status = STATUS_OP2_UNF;
        return r;
      end
      p = int'(precision);
      if (p < 1) p = 1;
      if (p > OUT_DIGITS) p = OUT_DIGITS;
      sa = it.sign_a;
      sb = it.sign_b ^ (it.opcode == OP_SUB);
      if (ea >= eb) begin
        e = ea;
        sh_a = 0;
        sh_b = ea - eb;
      end else begin
        e = eb;
        sh_a = eb - ea;
        sh_b = 0;
      end
      a = align(it.digits_a, sh_a);
      b = align(it.digits_b, sh_b);
      if (sa == sb) begin
        mag = a + b;
        sign = sa;
      end else if (a >= b) begin
        mag = a - b;
        sign = sa;
      end else begin
        mag = b - a;
        sign = sb;
      end
      if (mag == 0) return r;
      n = 0;
      while (n < 19 && mag >= ten_pow(n)) n++;
      e += n - WORK;
      if (n > p) begin
        dv = ten_pow(n - p);
        rem = mag % dv;
        half = dv / 2;
        q = mag / dv;
        if (rem > half || (rem == half && q[0])) q++;
        if (q == ten_pow(p)) begin
          q = ten_pow(p - 1);
          e++;
        end
      end else begin
        q = mag * ten_pow(p - n);
      end
      if (e > hi) begin
        r.status = STATUS_RES_OVF;
        return r;
      end
      if (e < lo) begin
        r.status = STATUS_RES_UNF;
        return r;
      end
      r.sign = sign;
      for (int i = 0; i < p; i++) begin
        r.digits[4*(OUT_DIGITS-p+i) +: 4] = 4'(q % 10);
        q = q / 10;
      end
      r.exponent = 9'(e);
      return r;
    endfunction

    function void note_item(operation_t it);
      expected_q.push_back(rounded_sum(it));
    endfunction

    function void check_result(res_t got);
      res_t want;
      results_seen++;
      status_seen[3'(got.status)]++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result %0d: status %0d sign %0d digits %h exp %0d",
                   results_seen, got.status, got.sign, got.digits, $signed(got.exponent));
        return;
      end
      want = expected_q.pop_front();
      if (got.status != want.status || got.sign != want.sign ||
          got.digits != want.digits || got.exponent != want.exponent) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch at result %0d", results_seen);
          $display("  expected status %0d sign %0d digits %h exp %0d",
                   want.status, want.sign, want.digits, $signed(want.exponent));
          $display("  actual   status %0d sign %0d digits %h exp %0d",
                   got.status, got.sign, got.digits, $signed(got.exponent));
        end
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CFG_IDX_W-1:0]   cfg_index_i;
  logic [CFG_DATA_W-1:0]  cfg_data_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  // first_sign, first_digits, first_exponent, second_sign, second_digits,
  // second_exponent
  logic [IN_W-1:0]        s_axis_tdata;
  // opcode
  logic                   s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  // result_sign, result_digits, result_exponent
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  // status
  logic [2:0]             m_axis_tuser;

  dfas_scoreboard board;
  bit steady;
  int unsigned items_sent;

  decimal_float_add_sub_unit DUT (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_data_i,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic logic [4*OPD-1:0] random_bcd();
    logic [4*OPD-1:0] v;
    for (int i = 0; i < OPD; i++) v[4*i +: 4] = 4'($urandom_range(9, 0));
    return v;
  endfunction

  function automatic operation_t random_operation();
    operation_t it;
    int lo, hi, ea, eb, kind;
    lo = int'(signed'(board.exp_min));
    hi = int'(board.exp_max);
    kind = $urandom_range(99, 0);
    it.opcode   = 1'($urandom_range(1, 0));
    it.sign_a   = 1'($urandom_range(1, 0));
    it.sign_b   = 1'($urandom_range(1, 0));
    it.digits_a = random_bcd();
    it.digits_b = random_bcd();
    ea = lo + int'($urandom_range(hi - lo, 0));
    eb = ($urandom_range(1, 0) != 0) ? ea + int'($urandom_range(16, 0))
                                     : ea - int'($urandom_range(16, 0));
    if (eb < lo || eb > hi) eb = ea;
    if (kind < 15) begin
      it.digits_b = it.digits_a;
      it.digits_b[3:0] = 4'($urandom_range(9, 0));
      it.opcode = (it.sign_a == it.sign_b) ? OP_SUB : OP_ADD;
      eb = ea;
    end else if (kind < 25) begin
      it.digits_a = (4*OPD)'($urandom);
      it.digits_b = (4*OPD)'($urandom);
    end else if (kind < 35) begin
      ea = int'(signed'(8'($urandom)));
      eb = int'(signed'(8'($urandom)));
    end else if (kind < 42) begin
      eb = lo + int'($urandom_range(hi - lo, 0));
    end else if (kind < 50) begin
      it.digits_a = it.digits_a >> (4 * $urandom_range(OPD, 0));
      it.digits_b = it.digits_b >> (4 * $urandom_range(OPD, 0));
    end
    it.exp_a = 8'(ea);
    it.exp_b = 8'(eb);
    return it;
  endfunction

  task automatic send_operation(operation_t it);
    if (!steady && $urandom_range(4, 0) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(11, 1)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_W'({it.exp_b, it.digits_b, it.sign_b,
                            it.exp_a, it.digits_a, it.sign_a});
    s_axis_tuser  <= it.opcode;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_item(it);
    items_sent++;
  endtask

  task automatic apply(logic op, logic sa, logic [4*OPD-1:0] da, int ea,
                       logic sb, logic [4*OPD-1:0] db, int eb);
    operation_t it;
    it = '{opcode: op, sign_a: sa, digits_a: da, exp_a: 8'(ea),
           sign_b: sb, digits_b: db, exp_b: 8'(eb)};
    send_operation(it);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  task automatic program_phase(int k);
    logic [3:0] prec;
    logic [7:0] lo;
    logic [6:0] hi;
    case (k)
      1:       begin prec = 4'd14; lo = 8'(-128); hi = 7'd127; end
      2:       begin prec = 4'd1;  lo = 8'd0;     hi = 7'd0;   end
      3:       begin prec = 4'd0;  lo = 8'(-50);  hi = 7'd50;  end
      4:       begin prec = 4'd15; lo = 8'(-10);  hi = 7'd120; end
      5:       begin prec = 4'd3;  lo = 8'(-128); hi = 7'd0;   end
      default: begin prec = 4'd10; lo = 8'(-20);  hi = 7'd60;  end
    endcase
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_PRECISION;
    cfg_data_i  <= {4'd0, prec};
    @(posedge clk_i);
    cfg_index_i <= CFG_EXP_MIN;
    cfg_data_i  <= lo;
    @(posedge clk_i);
    cfg_index_i <= CFG_EXP_MAX;
    cfg_data_i  <= {1'b0, hi};
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.set_config(prec, lo, hi);
  endtask

  always @(posedge clk_i) begin : result_monitor
    res_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.status   = status_e'(m_axis_tuser);
      got.sign     = m_axis_tdata[0];
      got.digits   = m_axis_tdata[4*OUT_DIGITS:1];
      got.exponent = m_axis_tdata[4*OUT_DIGITS+RES_EXP_W:4*OUT_DIGITS+1];
      board.check_result(got);
    end
  end

  initial begin : result_sink
    int run;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!steady && $urandom_range(3, 0) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(11, 1)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      run = ($urandom_range(3, 0) == 0) ? $urandom_range(60, 20) : $urandom_range(8, 1);
      repeat (run) @(posedge clk_i);
    end
  end

  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    board = new();
    steady = 1'b0;
    items_sent = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = CFG_PRECISION;
    cfg_data_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = OP_ADD;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed operations under the reset settings
    apply(OP_ADD, PLUS,  28'h1234567, 0,    PLUS,  28'h7654321, 0);
    apply(OP_ADD, PLUS,  28'h9999999, 0,    PLUS,  28'h9999999, 0);
    apply(OP_SUB, PLUS,  28'h1234567, 0,    PLUS,  28'h1234567, 0);
    apply(OP_ADD, PLUS,  28'h0000000, 0,    MINUS, 28'h0000000, 0);
    apply(OP_SUB, PLUS,  28'h1000000, 0,    PLUS,  28'h9999999, -1);
    apply(OP_ADD, PLUS,  28'h1234567, 0,    PLUS,  28'h5000000, -7);
    apply(OP_ADD, PLUS,  28'h1234566, 0,    PLUS,  28'h5000000, -7);
    apply(OP_ADD, PLUS,  28'h9999999, 0,    PLUS,  28'h5000000, -7);
    apply(OP_ADD, PLUS,  28'h9999999, 99,   PLUS,  28'h9999999, 99);
    apply(OP_SUB, PLUS,  28'h1000000, -99,  PLUS,  28'h9999999, -100 + 1);
    apply(OP_SUB, MINUS, 28'h1000000, -99,  MINUS, 28'h9999990, -100 + 1);
    apply(OP_ADD, PLUS,  28'h1234567, 100,  PLUS,  28'h1234567, 0);
    apply(OP_ADD, PLUS,  28'h1234567, -100, PLUS,  28'h1234567, 0);
    apply(OP_ADD, PLUS,  28'h1234567, 0,    PLUS,  28'h1234567, 127);
    apply(OP_ADD, PLUS,  28'h1234567, 0,    PLUS,  28'h1234567, -128);
    apply(OP_ADD, PLUS,  28'h1234567, 127,  PLUS,  28'h1234567, -128);
    apply(OP_ADD, PLUS,  28'h1234567, -128, PLUS,  28'h1234567, 127);
    apply(OP_ADD, PLUS,  28'hFFFFFFF, 0,    PLUS,  28'hABCDEF0, 0);
    apply(OP_ADD, PLUS,  28'h1234567, 20,   PLUS,  28'h7654321, 0);
    apply(OP_ADD, PLUS,  28'h1234567, 10,   PLUS,  28'h7654321, 0);
    apply(OP_SUB, MINUS, 28'h1234567, 3,    MINUS, 28'h7654321, 3);
    apply(OP_ADD, PLUS,  28'h1234567, 0,    MINUS, 28'h7654321, 2);
    apply(OP_SUB, PLUS,  28'h4444444, -5,   MINUS, 28'h5555555, -5);
    apply(OP_SUB, MINUS, 28'hFFFFFFF, 99,   PLUS,  28'hFFFFFFF, 99);
    apply(OP_ADD, PLUS,  28'h0000001, 0,    PLUS,  28'h0000000, 0);

    for (int k = 0; k < PHASES; k++) begin
      if (k > 0) begin
        drain();
        if (k == PHASES - 1) steady = 1'b1;
        program_phase(k);
      end
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
        if (k == 3 && i == RANDOM_PER_PHASE / 2) drain();
        send_operation(random_operation());
      end
    end

    drain();
    repeat (8) @(posedge clk_i);
    $display("covered %0d operations over %0d register settings, precision 0 to 15",
             items_sent, PHASES);
    $display("status seen: ok %0d, result ovf/unf %0d/%0d, operand faults %0d",
             board.status_seen[STATUS_OK], board.status_seen[STATUS_RES_OVF],
             board.status_seen[STATUS_RES_UNF],
             board.status_seen[STATUS_OP1_OVF] + board.status_seen[STATUS_OP1_UNF] +
             board.status_seen[STATUS_OP2_OVF] + board.status_seen[STATUS_OP2_UNF]);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches", board.mismatches);
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
